### rtl/assert_macros.svh
// Assertion macros for the RTL, included by the arithmetic unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check an implication whose consequence is due in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/gf2m_pkg.sv
// Package with the payload types, op codes and field tables of the GF(2^m) unit
`timescale 1ns / 1ps
package gf2m_pkg;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_MUL = 3'd1,
    OP_DIV = 3'd2,
    OP_POW = 3'd3,
    OP_INV = 3'd4
  } gf_op_t;

  typedef struct packed {
    logic [2:0]         op;
    logic [7:0]         operand_a;
    logic [7:0]         operand_b;
    logic signed [15:0] exponent;
  } gf_in_t;

  typedef struct packed {
    logic [7:0] result;
    logic       div_by_zero;
  } gf_out_t;

  // One 256-entry symbol table for each field width from 2 to 8
  typedef logic [6:0][255:0][7:0] tab_set_t;

  localparam logic [3:0] FIELD_BITS_RESET = 4'd8;

  // Primitive polynomial for field width m
  function automatic logic [8:0] prim_poly(input logic [3:0] m);
    logic [8:0] p;
    case (m)
      4'd2:    p = 9'h007;
      4'd3:    p = 9'h00B;
      4'd4:    p = 9'h013;
      4'd5:    p = 9'h025;
      4'd6:    p = 9'h043;
      4'd7:    p = 9'h089;
      4'd8:    p = 9'h11D;
      default: p = 9'h003;
    endcase
    return p;
  endfunction

  // Floor of 2^17 / (2^m - 1), used to estimate quotients by the order
  function automatic logic [15:0] mod_rcp(input logic [3:0] m);
    logic [15:0] r;
    case (m)
      4'd2:    r = 16'd43690;
      4'd3:    r = 16'd18724;
      4'd4:    r = 16'd8738;
      4'd5:    r = 16'd4228;
      4'd6:    r = 16'd2080;
      4'd7:    r = 16'd1032;
      default: r = 16'd514;
    endcase
    return r;
  endfunction

  // Smallest multiple of 2^m - 1 that lifts any 16-bit signed exponent to zero or above
  function automatic logic [16:0] exp_offset(input logic [3:0] m);
    logic [16:0] r;
    case (m)
      4'd2:    r = 17'd32769;
      4'd3:    r = 17'd32774;
      4'd4:    r = 17'd32775;
      4'd5:    r = 17'd32798;
      4'd6:    r = 17'd32823;
      4'd7:    r = 17'd32893;
      default: r = 17'd32895;
    endcase
    return r;
  endfunction

  // Antilog tables: alpha^i for every width, zero past 2^m - 2
  function automatic tab_set_t build_alog_tabs();
    tab_set_t   t;
    logic [8:0] x;
    logic [8:0] poly;
    t = '0;
    for (int mm = 2; mm <= 8; mm++) begin
      poly = prim_poly(4'(mm));
      x = 9'd1;
      for (int i = 0; i < (1 << mm) - 1; i++) begin
        t[3'(mm - 2)][8'(i)] = x[7:0];
        x = {x[7:0], 1'b0};
        if (x[4'(mm)]) x = x ^ poly;
      end
    end
    return t;
  endfunction

  // Log tables for every width, zero for the zero symbol
  function automatic tab_set_t build_log_tabs();
    tab_set_t   t;
    logic [8:0] x;
    logic [8:0] poly;
    t = '0;
    for (int mm = 2; mm <= 8; mm++) begin
      poly = prim_poly(4'(mm));
      x = 9'd1;
      for (int i = 0; i < (1 << mm) - 1; i++) begin
        t[3'(mm - 2)][x[7:0]] = 8'(i);
        x = {x[7:0], 1'b0};
        if (x[4'(mm)]) x = x ^ poly;
      end
    end
    return t;
  endfunction

endpackage

### rtl/gf2m_arithmetic_unit.sv
// GF(2^m) arithmetic unit: seven-stage pipeline over log and antilog tables
`timescale 1ns / 1ps
// Channel  | Ports                               | Handshake
// input    | in_start, in_busy, in_item          | transfer when start and !busy
// result   | out_strobe, out_item                | one cycle, no backpressure
// config   | cfg_valid, cfg_ready, cfg_field_bits| transfer when valid and ready
// One item enters every cycle; busy is always low.
// Stages: log lookup, exponent quotient, exponent remainder, log sum, difference or product,
// log quotient, log remainder, antilog lookup.
// An item's result is on the result ports once it leaves the antilog lookup stage.
// Synchronous active-low reset clears valid bits and sets the field width register to 8.
// The receiver cannot stall, so the pipeline never halts.
module gf2m_arithmetic_unit
  import gf2m_pkg::*;
#(
  parameter int MAX_FIELD_BITS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_start,
  output logic       in_busy,
  input  gf_in_t     in_item,
  output logic       out_strobe,
  output gf_out_t    out_item,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [3:0] cfg_field_bits
);
  `include "assert_macros.svh"

  localparam tab_set_t LOG_TABS  = build_log_tabs();
  localparam tab_set_t ALOG_TABS = build_alog_tabs();

  logic [3:0]  field_bits_r;
  logic [3:0]  m;
  logic [2:0]  tsel;
  logic [7:0]  order;
  logic [7:0]  mask;
  logic [15:0] rcp;

  // Hold the field width register
  always_ff @(posedge clk) begin
    if (!rst_n) field_bits_r <= FIELD_BITS_RESET;
    else if (cfg_valid && cfg_ready) field_bits_r <= cfg_field_bits;
  end
  assign cfg_ready = 1'b1;
  assign in_busy = 1'b0;

  // Clamp width and derive order, table select and reciprocal
  always_comb begin
    if (field_bits_r < 4'd2) m = 4'd2;
    else if (field_bits_r > 4'(MAX_FIELD_BITS)) m = 4'(MAX_FIELD_BITS);
    else m = field_bits_r;
    order = 8'((9'd1 << m) - 9'd1);
    mask = order;
    tsel = 3'(m - 4'd2);
    rcp = mod_rcp(m);
  end

  // Stage 1: mask operands, look up logs, offset exponent
  logic        v1_r;
  gf_op_t      op1_r;
  logic        az1_r, bz1_r;
  logic [7:0]  la1_r, lb1_r, ab1_r;
  logic [16:0] ex1_r;
  logic [7:0]  a_m, b_m;
  logic [16:0] e_off;

  assign a_m = in_item.operand_a & mask;
  assign b_m = in_item.operand_b & mask;
  // Offset the exponent by a multiple of order so that it is never negative
  assign e_off = {in_item.exponent[15], in_item.exponent} + exp_offset(m);

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else v1_r <= in_start;
    op1_r <= gf_op_t'(in_item.op);
    ab1_r <= a_m ^ b_m;
    az1_r <= (a_m == 8'd0);
    bz1_r <= (b_m == 8'd0);
    la1_r <= LOG_TABS[tsel][a_m];
    lb1_r <= LOG_TABS[tsel][b_m];
    ex1_r <= e_off;
  end

  // Stage 2: estimate exponent quotient by the order
  logic        v2_r;
  gf_op_t      op2_r;
  logic        az2_r, bz2_r;
  logic [7:0]  la2_r, lb2_r, ab2_r;
  logic [16:0] ex2_r;
  logic [15:0] eq2_r;
  logic [32:0] eprod;

  assign eprod = {16'd0, ex1_r} * {17'd0, rcp};

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else v2_r <= v1_r;
    op2_r <= op1_r;
    az2_r <= az1_r;
    bz2_r <= bz1_r;
    ab2_r <= ab1_r;
    la2_r <= la1_r;
    lb2_r <= lb1_r;
    ex2_r <= ex1_r;
    eq2_r <= eprod[32:17];
  end

  // Stage 3: exponent remainder, one correction step
  logic       v3_r;
  gf_op_t     op3_r;
  logic       az3_r, bz3_r;
  logic [7:0] la3_r, lb3_r, ab3_r, ep3_r;
  logic [8:0] er_raw;
  logic [7:0] ep_nxt;

  always_comb begin
    er_raw = 9'(ex2_r - ((17'(eq2_r) << m) - 17'(eq2_r)));
    if (er_raw >= {1'b0, order}) ep_nxt = 8'(er_raw - {1'b0, order});
    else ep_nxt = er_raw[7:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else v3_r <= v2_r;
    op3_r <= op2_r;
    az3_r <= az2_r;
    bz3_r <= bz2_r;
    ab3_r <= ab2_r;
    la3_r <= la2_r;
    lb3_r <= lb2_r;
    ep3_r <= ep_nxt;
  end

  // Stage 4: form the log of the result
  logic        v4_r;
  gf_op_t      op4_r;
  logic        az4_r, bz4_r;
  logic [7:0]  ab4_r;
  logic [15:0] ls4_r;
  logic [15:0] ls_nxt;

  always_comb begin
    case (op3_r)
      OP_MUL:  ls_nxt = 16'(la3_r) + 16'(lb3_r);
      OP_DIV:  ls_nxt = 16'(la3_r) + 16'(order) - 16'(lb3_r);
      OP_POW:  ls_nxt = 16'(la3_r) * 16'(ep3_r);
      OP_INV:  ls_nxt = 16'(order) - 16'(la3_r);
      default: ls_nxt = 16'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else v4_r <= v3_r;
    op4_r <= op3_r;
    az4_r <= az3_r;
    bz4_r <= bz3_r;
    ab4_r <= ab3_r;
    ls4_r <= ls_nxt;
  end

  // Stage 5: estimate log quotient by the order
  logic        v5_r;
  gf_op_t      op5_r;
  logic        az5_r, bz5_r;
  logic [7:0]  ab5_r;
  logic [15:0] ls5_r, lq5_r;
  logic [32:0] lprod;

  assign lprod = {17'd0, ls4_r} * {17'd0, rcp};

  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else v5_r <= v4_r;
    op5_r <= op4_r;
    az5_r <= az4_r;
    bz5_r <= bz4_r;
    ab5_r <= ab4_r;
    ls5_r <= ls4_r;
    lq5_r <= lprod[32:17];
  end

  // Stage 6: log remainder, one correction step
  logic       v6_r;
  gf_op_t     op6_r;
  logic       az6_r, bz6_r;
  logic [7:0] ab6_r, lr6_r;
  logic [8:0] lr_raw;
  logic [7:0] lr_nxt;

  always_comb begin
    lr_raw = 9'({1'b0, ls5_r} - ((17'(lq5_r) << m) - 17'(lq5_r)));
    if (lr_raw >= {1'b0, order}) lr_nxt = 8'(lr_raw - {1'b0, order});
    else lr_nxt = lr_raw[7:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v6_r <= 1'b0;
    else v6_r <= v5_r;
    op6_r <= op5_r;
    az6_r <= az5_r;
    bz6_r <= bz5_r;
    ab6_r <= ab5_r;
    lr6_r <= lr_nxt;
  end

  // Stage 7: antilog and select result
  gf_out_t    res_nxt;
  logic [7:0] alog_val;
  logic       v7_r;
  gf_out_t    out_r;

  assign alog_val = ALOG_TABS[tsel][lr6_r];

  always_comb begin
    res_nxt = '0;
    case (op6_r)
      OP_ADD: res_nxt.result = ab6_r;
      OP_MUL: if (!az6_r && !bz6_r) res_nxt.result = alog_val;
      OP_DIV: begin
        if (bz6_r) res_nxt.div_by_zero = 1'b1;
        else if (!az6_r) res_nxt.result = alog_val;
      end
      OP_POW, OP_INV: if (!az6_r) res_nxt.result = alog_val;
      default: res_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v7_r <= 1'b0;
    else v7_r <= v6_r;
    out_r <= res_nxt;
  end

  assign out_strobe = v7_r;
  assign out_item   = out_r;

  `ASSERT_NEXT(a_pipe_advance, clk, rst_n, v6_r, v7_r, "valid lost in pipe")
  `ASSERT_IMPL(a_dz_only_div, clk, rst_n, out_strobe && out_item.div_by_zero,
               out_item.result == 8'd0, "div by zero with nonzero result")
  `ASSERT_IMPL(a_never_busy, clk, rst_n, 1'b1, !in_busy, "busy raised")

endmodule

### test/gf2m_checker.sv
// Checker for the GF(2^m) unit: predicts each result and compares it with the block output
`timescale 1ns / 1ps
module gf2m_checker
  import gf2m_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_start,
  input  logic       in_busy,
  input  gf_in_t     in_item,
  input  logic       out_strobe,
  input  gf_out_t    out_item,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [3:0] cfg_field_bits,
  output int         fail_count,
  output int         pending_count
);

  int unsigned ord;
  int unsigned alog_tab[256];
  int unsigned log_tab[256];
  gf_out_t     expected_q[$];

  // Rebuild the field tables for width m
  function automatic void build_field(input logic [3:0] fb);
    int unsigned mm;
    int unsigned x;
    int unsigned poly;
    mm = fb;
    if (mm < 2) mm = 2;
    if (mm > 8) mm = 8;
    ord = (1 << mm) - 1;
    case (mm)
      2: poly = 'h007;
      3: poly = 'h00B;
      4: poly = 'h013;
      5: poly = 'h025;
      6: poly = 'h043;
      7: poly = 'h089;
      default: poly = 'h11D;
    endcase
    for (int i = 0; i < 256; i++) begin
      alog_tab[i] = 0;
      log_tab[i] = 0;
    end
    x = 1;
    for (int i = 0; i < ord; i++) begin
      alog_tab[i] = x;
      log_tab[x & 255] = i;
      x = x << 1;
      if (x & (1 << mm)) x = x ^ poly;
      x = x & ord;
    end
  endfunction

  function automatic int unsigned alpha_pow(input int unsigned e);
    return alog_tab[(e % ord) & 255];
  endfunction

  // Compute the expected symbol and flag for one operation
  function automatic gf_out_t field_op(input gf_in_t it);
    gf_out_t     r;
    int unsigned a;
    int unsigned b;
    int          e;
    int          rr;
    a = it.operand_a & ord;
    b = it.operand_b & ord;
    e = int'(it.exponent);
    r = '0;
    case (it.op)
      OP_ADD: r.result = 8'(a ^ b);
      OP_MUL: if (a != 0 && b != 0) r.result = 8'(alpha_pow(log_tab[a] + log_tab[b]));
      OP_DIV: begin
        if (b == 0) r.div_by_zero = 1'b1;
        else if (a != 0) r.result = 8'(alpha_pow(log_tab[a] + ord - log_tab[b]));
      end
      OP_POW: if (a != 0) begin
        rr = e % int'(ord);
        if (rr < 0) rr += int'(ord);
        r.result = 8'(alpha_pow(log_tab[a] * rr));
      end
      OP_INV: if (a != 0) r.result = 8'(alpha_pow(ord - log_tab[a]));
      default: ;
    endcase
    return r;
  endfunction

  assign pending_count = expected_q.size();

  // Track transfers, predict and compare
  always @(posedge clk) begin
    gf_out_t want;
    if (!rst_n) begin
      build_field(FIELD_BITS_RESET);
      expected_q.delete();
      fail_count <= 0;
    end else begin
      if (out_strobe) begin
        if (expected_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %p", out_item);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (want.result !== out_item.result || want.div_by_zero !== out_item.div_by_zero) begin
            if (fail_count < 10)
              $display("mismatch: expected %h/%b actual %h/%b", want.result,
                       want.div_by_zero, out_item.result, out_item.div_by_zero);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_start && !in_busy) expected_q.push_back(field_op(in_item));
      if (cfg_valid && cfg_ready) build_field(cfg_field_bits);
    end
  end

endmodule

### test/testbench.sv
// Testbench top: drives the GF(2^m) unit and reports the verdict
`timescale 1ns / 1ps
module testbench;
  import gf2m_pkg::*;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_start = 1'b0;
  logic       in_busy;
  gf_in_t     in_item = '0;
  logic       out_strobe;
  gf_out_t    out_item;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [3:0] cfg_field_bits = 4'd8;
  int         fail_count;
  int         pending_count;
  int         cycle_count = 0;

  localparam int CYCLE_LIMIT = 200000;

  always #5 clk = ~clk;

  gf2m_arithmetic_unit u_top (.*);
  gf2m_checker u_check (.*);

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Hold start for one transfer of an item
  task automatic send_op(input logic [2:0] op, input logic [7:0] a, input logic [7:0] b,
                         input logic [15:0] e);
    in_start <= 1'b1;
    in_item <= '{op: op, operand_a: a, operand_b: b, exponent: e};
    @(posedge clk);
    while (in_busy) @(posedge clk);
    @(negedge clk);
  endtask

  // Drain the pipeline, then write the field width
  task automatic set_width(input logic [3:0] fb);
    in_start <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (6) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_field_bits <= fb;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random operation, mostly valid codes
  task automatic send_random();
    logic [2:0] op;
    op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
    send_op(op, ($urandom_range(0, 5) == 0) ? 8'd0 : 8'($urandom),
            ($urandom_range(0, 5) == 0) ? 8'd0 : 8'($urandom), 16'($urandom));
  endtask

  initial begin
    int burst;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: extremes, zero cases, every op, unused codes
    send_op(OP_ADD, 8'hFF, 8'h00, 16'h0000);
    send_op(OP_MUL, 8'hFF, 8'hFF, 16'h0000);
    send_op(OP_MUL, 8'h00, 8'h57, 16'h0000);
    send_op(OP_DIV, 8'h35, 8'h00, 16'h0000);
    send_op(OP_DIV, 8'h00, 8'h12, 16'h0000);
    send_op(OP_DIV, 8'hFF, 8'h02, 16'h0000);
    send_op(OP_POW, 8'h00, 8'h00, 16'h0000);
    send_op(OP_POW, 8'h02, 8'h00, 16'h8000);
    send_op(OP_POW, 8'h03, 8'h00, 16'h7FFF);
    send_op(OP_POW, 8'h05, 8'h00, 16'hFFFF);
    send_op(OP_INV, 8'h00, 8'h00, 16'h0000);
    send_op(OP_INV, 8'hFF, 8'h00, 16'h0000);
    send_op(3'd5, 8'h12, 8'h34, 16'h1234);
    send_op(3'd7, 8'hFF, 8'hFF, 16'hFFFF);
    set_width(4'd2);
    send_op(OP_MUL, 8'hFF, 8'hFE, 16'h0000);
    send_op(OP_DIV, 8'hFC, 8'h03, 16'h0000);
    send_op(OP_POW, 8'hFE, 8'h00, 16'h8001);
    send_op(OP_INV, 8'hF3, 8'h00, 16'h0000);
    set_width(4'd0);
    send_op(OP_ADD, 8'hAB, 8'hCD, 16'h0000);
    set_width(4'd15);
    send_op(OP_MUL, 8'hAB, 8'hCD, 16'h0000);

    // Random phases over several widths, in bursts
    for (int ph = 0; ph < 9; ph++) begin
      set_width(4'($urandom_range(0, 15)));
      for (int n = 0; n < 85; n += burst) begin
        burst = $urandom_range(1, 20);
        for (int k = 0; k < burst; k++) send_random();
        if (n == 40) begin
          in_start <= 1'b0;
          while (pending_count != 0) @(negedge clk);
        end else if ($urandom_range(0, 2) != 0) begin
          in_start <= 1'b0;
          repeat ($urandom_range(1, 6)) @(negedge clk);
        end
      end
    end
    set_width(4'd8);
    for (int k = 0; k < 20; k++) send_random();
    in_start <= 1'b0;

    while (pending_count != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/gf2m_pkg.sv
rtl/gf2m_arithmetic_unit.sv
test/gf2m_checker.sv
test/testbench.sv
